// ----- src/med3x3_pkg.sv -----
// ----------------------------------------------------------------------------
// med3x3_pkg
// Shared constants and register codes for the 3x3 median image filter.
// ----------------------------------------------------------------------------
package med3x3_pkg;

  // Default sizing of the filter
  localparam int DEF_MAX_COLS   = 1024;
  localparam int DEF_MAX_ROWS   = 4096;
  localparam int DEF_PIXEL_BITS = 8;

  // Neighborhood geometry
  localparam int WIN_DIM  = 3;
  localparam int WIN_SIZE = WIN_DIM * WIN_DIM;

  // Configuration port layout
  localparam int CFG_COLS_W = 11;
  localparam int CFG_ROWS_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  // Register values after reset
  localparam int RST_FRAME_COLS = 1024;
  localparam int RST_FRAME_ROWS = 1024;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_COLS = 1'b0,
    CFG_FRAME_ROWS = 1'b1
  } cfg_reg_e;

endpackage

// ----- src/median_3x3_image_filter.sv -----
// ----------------------------------------------------------------------------
// median_3x3_image_filter
// Streaming 3x3 median filter with replicated borders and frame min/max.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes pixels of a frame in raster
//   order (kind 0), then flush steps (kind 1) that drain the final row. Output
//   channel (out_valid_o / out_stall_i) gives medians in raster order, each
//   with row/frame end flags and the running min and max of the frame.
//   Configuration (cfg_we_i, cfg_index_i, cfg_data_i) sets frame columns and
//   rows; a write restarts the frame. Users write only while idle; not enforced.
// Flow:
//   One item is taken per cycle while in_stall_o is low. With more than one
//   column, the last item of a row that gives results produces two of them
//   and holds the input while it makes the second. Results pass the read,
//   snapshot, sort, reduction and output registers; the second result of a
//   row end follows the first. Results lag the input by one row plus one
//   pixel. The single line memory holds both previous rows in one entry per
//   column, read when an item is taken and written back as it leaves.
// Reset and stall:
//   Reset restarts the frame and sets 1024 columns and 1024 rows; the line
//   memory is not cleared. When out_stall_i holds a result, the whole result
//   pipeline holds and in_stall_o rises once the item in flight must wait.
// ----------------------------------------------------------------------------
module median_3x3_image_filter
  import med3x3_pkg::*;
#(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  in_kind_i,
  input  logic [PIXEL_BITS-1:0] in_pixel_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIXEL_BITS-1:0] out_median_o,
  output logic                  out_row_end_o,
  output logic                  out_frame_end_o,
  output logic [PIXEL_BITS-1:0] out_frame_min_o,
  output logic [PIXEL_BITS-1:0] out_frame_max_o,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ENT_W  = 2 * PIXEL_BITS;

  localparam int RST_LAST_COL =
    ((RST_FRAME_COLS > MAX_COLS) ? MAX_COLS : RST_FRAME_COLS) - 1;
  localparam int RST_LAST_ROW =
    ((RST_FRAME_ROWS > MAX_ROWS) ? MAX_ROWS : RST_FRAME_ROWS) - 1;

  localparam logic [PIXEL_BITS-1:0] PIX_ONES = {PIXEL_BITS{1'b1}};

  // Item state carried from the transfer into the memory read stage
  typedef struct packed {
    logic [ADDR_W-1:0]     addr;
    logic [PIXEL_BITS-1:0] pix;
    logic                  wr;        // pixel: write the column back
    logic                  proc;      // item loads the window
    logic                  top_mid;   // top row replicates the middle row
    logic                  bot_mid;   // bottom row replicates the middle row
    logic                  first;     // column 0
    logic                  last;      // last column of the row
    logic                  last_row;  // flush of the final row
  } s1_item_t;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [PIXEL_BITS-1:0] min2(logic [PIXEL_BITS-1:0] a,
                                                logic [PIXEL_BITS-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIXEL_BITS-1:0] max2(logic [PIXEL_BITS-1:0] a,
                                                logic [PIXEL_BITS-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [PIXEL_BITS-1:0] med3(logic [PIXEL_BITS-1:0] a,
                                                logic [PIXEL_BITS-1:0] b,
                                                logic [PIXEL_BITS-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic logic [ADDR_W-1:0] clamp_cols(logic [CFG_COLS_W-1:0] v);
    int unsigned n;
    n = unsigned'(int'(v));
    if (n == 0) n = 1;
    if (n > unsigned'(MAX_COLS)) n = unsigned'(MAX_COLS);
    return ADDR_W'(n - 1);
  endfunction

  function automatic logic [ROW_W-1:0] clamp_rows(logic [CFG_ROWS_W-1:0] v);
    int unsigned n;
    n = unsigned'(int'(v));
    if (n == 0) n = 1;
    if (n > unsigned'(MAX_ROWS)) n = unsigned'(MAX_ROWS);
    return ROW_W'(n - 1);
  endfunction

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0]     last_col_q;
  logic [ROW_W-1:0]      last_row_q;
  logic [ADDR_W-1:0]     col_q, drain_q;
  logic [ROW_W-1:0]      row_q;
  logic                  rows_in_q;

  logic                  adv;
  logic                  in_fire;
  logic                  ignored;
  logic [ADDR_W-1:0]     c_sel;

  logic [ENT_W-1:0]      line_mem [MAX_COLS];
  logic                  rd_en, wr_en;
  logic [ENT_W-1:0]      wr_data;
  logic [ENT_W-1:0]      rdata_q, fwd_data_q;
  logic                  fwd_q;
  logic [ENT_W-1:0]      ent;

  s1_item_t              s1_d, s1_q;
  logic                  s1_valid_q;
  logic                  phase_q;
  logic                  s1_two, s1_done;

  logic [PIXEL_BITS-1:0] col_top, col_mid, col_bot;
  logic [PIXEL_BITS-1:0] win_q [WIN_SIZE];
  logic [PIXEL_BITS-1:0] win_d [WIN_SIZE];
  logic                  emit, emit_rend, emit_fend;

  logic                  snap_valid_q, snap_rend_q, snap_fend_q;
  logic [PIXEL_BITS-1:0] snap_win_q [WIN_SIZE];

  logic                  srt_valid_q, srt_rend_q, srt_fend_q;
  logic [PIXEL_BITS-1:0] srt_lo_q [WIN_DIM];
  logic [PIXEL_BITS-1:0] srt_md_q [WIN_DIM];
  logic [PIXEL_BITS-1:0] srt_hi_q [WIN_DIM];

  logic                  red_valid_q, red_rend_q, red_fend_q;
  logic [PIXEL_BITS-1:0] red_lo_q, red_md_q, red_hi_q;

  logic [PIXEL_BITS-1:0] med_val, new_min, new_max;
  logic [PIXEL_BITS-1:0] run_min_q, run_max_q;
  logic                  out_valid_q, out_rend_q, out_fend_q;
  logic [PIXEL_BITS-1:0] out_med_q, out_min_q, out_max_q;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_done;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Drop pixels after the last row and flush steps before it
  assign ignored = in_kind_i ? !rows_in_q : rows_in_q;
  assign c_sel   = in_kind_i ? drain_q : col_q;

  // --------------------------------------------------------------------------
  // Frame position and configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= ADDR_W'(RST_LAST_COL);
      last_row_q <= ROW_W'(RST_LAST_ROW);
      col_q      <= '0;
      row_q      <= '0;
      drain_q    <= '0;
      rows_in_q  <= 1'b0;
    end else if (cfg_we_i) begin
      // restart the frame on any register write
      case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_COLS: begin
          last_col_q <= clamp_cols(cfg_data_i[CFG_COLS_W-1:0]);
        end
        CFG_FRAME_ROWS: begin
          last_row_q <= clamp_rows(cfg_data_i[CFG_ROWS_W-1:0]);
        end
        default: begin
        end
      endcase
      col_q     <= '0;
      row_q     <= '0;
      drain_q   <= '0;
      rows_in_q <= 1'b0;
    end else if (in_fire && !ignored) begin
      if (!in_kind_i) begin
        // advance the input position
        if (col_q == last_col_q) begin
          col_q <= '0;
          if (row_q == last_row_q) begin
            rows_in_q <= 1'b1;
          end else begin
            row_q <= row_q + ROW_W'(1);
          end
        end else begin
          col_q <= col_q + ADDR_W'(1);
        end
      end else begin
        // advance the drain, restart after the last column
        if (drain_q == last_col_q) begin
          col_q     <= '0;
          row_q     <= '0;
          drain_q   <= '0;
          rows_in_q <= 1'b0;
        end else begin
          drain_q <= drain_q + ADDR_W'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line memory: {row above, current row} per column
  // --------------------------------------------------------------------------
  assign rd_en   = in_fire && !ignored;
  assign wr_en   = s1_valid_q && s1_q.wr && s1_done;
  assign wr_data = {ent[PIXEL_BITS-1:0], s1_q.pix};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[s1_q.addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q    <= line_mem[c_sel];
      fwd_data_q <= wr_data;
    end
  end

  // Forward a write-back that lands on the entry being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en) begin
      fwd_q <= wr_en && (s1_q.addr == c_sel);
    end
  end

  assign ent = fwd_q ? fwd_data_q : rdata_q;

  // --------------------------------------------------------------------------
  // Read stage: item state
  // --------------------------------------------------------------------------
  always_comb begin
    s1_d          = '0;
    s1_d.addr     = c_sel;
    s1_d.pix      = in_pixel_i;
    s1_d.wr       = !in_kind_i;
    s1_d.proc     = in_kind_i || (row_q != '0);
    s1_d.top_mid  = in_kind_i ? (last_row_q == '0) : (row_q == ROW_W'(1));
    s1_d.bot_mid  = in_kind_i;
    s1_d.first    = (c_sel == '0);
    s1_d.last     = (c_sel == last_col_q);
    s1_d.last_row = in_kind_i;
  end

  assign s1_two  = s1_q.proc && !s1_q.first && s1_q.last;
  assign s1_done = adv && (phase_q || !s1_two);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      phase_q    <= 1'b0;
    end else begin
      if (in_fire && !ignored) begin
        s1_valid_q <= 1'b1;
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end
      // second shift of a row end
      if (s1_valid_q && s1_done) begin
        phase_q <= 1'b0;
      end else if (s1_valid_q && adv && s1_two) begin
        phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !ignored) begin
      s1_q <= s1_d;
    end
  end

  // --------------------------------------------------------------------------
  // Window update and result snapshot
  // --------------------------------------------------------------------------
  assign col_mid = ent[PIXEL_BITS-1:0];
  assign col_top = s1_q.top_mid ? ent[PIXEL_BITS-1:0] : ent[ENT_W-1:PIXEL_BITS];
  assign col_bot = s1_q.bot_mid ? ent[PIXEL_BITS-1:0] : s1_q.pix;

  always_comb begin
    win_d     = win_q;
    emit      = 1'b0;
    emit_rend = 1'b0;
    emit_fend = 1'b0;
    if (s1_valid_q && s1_q.proc) begin
      if (s1_q.first && !phase_q) begin
        // replicate the first column to the left border
        for (int k = 0; k < WIN_DIM; k++) begin
          win_d[k*WIN_DIM]     = col_top;
          win_d[k*WIN_DIM + 1] = col_mid;
          win_d[k*WIN_DIM + 2] = col_bot;
        end
        emit      = s1_q.last;
        emit_rend = 1'b1;
        emit_fend = s1_q.last_row;
      end else begin
        // shift in the new column; the second shift replicates the right border
        for (int i = 0; i < WIN_SIZE - WIN_DIM; i++) begin
          win_d[i] = win_q[i + WIN_DIM];
        end
        win_d[WIN_SIZE-3] = col_top;
        win_d[WIN_SIZE-2] = col_mid;
        win_d[WIN_SIZE-1] = col_bot;
        emit      = 1'b1;
        emit_rend = phase_q;
        emit_fend = phase_q && s1_q.last_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_SIZE; i++) begin
        win_q[i] <= '0;
      end
    end else if (adv) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (adv) begin
      snap_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      snap_win_q  <= win_d;
      snap_rend_q <= emit_rend;
      snap_fend_q <= emit_fend;
    end
  end

  // --------------------------------------------------------------------------
  // Median network, stage 1: sort each column
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srt_valid_q <= 1'b0;
    end else if (adv) begin
      srt_valid_q <= snap_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < WIN_DIM; k++) begin
        srt_lo_q[k] <= min2(min2(snap_win_q[k*WIN_DIM], snap_win_q[k*WIN_DIM + 1]),
                            snap_win_q[k*WIN_DIM + 2]);
        srt_md_q[k] <= med3(snap_win_q[k*WIN_DIM], snap_win_q[k*WIN_DIM + 1],
                            snap_win_q[k*WIN_DIM + 2]);
        srt_hi_q[k] <= max2(max2(snap_win_q[k*WIN_DIM], snap_win_q[k*WIN_DIM + 1]),
                            snap_win_q[k*WIN_DIM + 2]);
      end
      srt_rend_q <= snap_rend_q;
      srt_fend_q <= snap_fend_q;
    end
  end

  // --------------------------------------------------------------------------
  // Median network, stage 2: max of lows, median of mids, min of highs
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_valid_q <= 1'b0;
    end else if (adv) begin
      red_valid_q <= srt_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_lo_q   <= max2(max2(srt_lo_q[0], srt_lo_q[1]), srt_lo_q[2]);
      red_md_q   <= med3(srt_md_q[0], srt_md_q[1], srt_md_q[2]);
      red_hi_q   <= min2(min2(srt_hi_q[0], srt_hi_q[1]), srt_hi_q[2]);
      red_rend_q <= srt_rend_q;
      red_fend_q <= srt_fend_q;
    end
  end

  // --------------------------------------------------------------------------
  // Final median, running extremes and output register
  // --------------------------------------------------------------------------
  assign med_val = med3(red_lo_q, red_md_q, red_hi_q);
  assign new_min = min2(run_min_q, med_val);
  assign new_max = max2(run_max_q, med_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      run_min_q   <= PIX_ONES;
      run_max_q   <= '0;
    end else if (cfg_we_i) begin
      run_min_q <= PIX_ONES;
      run_max_q <= '0;
    end else if (adv) begin
      out_valid_q <= red_valid_q;
      if (red_valid_q) begin
        // restart the extremes after the last result of a frame
        run_min_q <= red_fend_q ? PIX_ONES : new_min;
        run_max_q <= red_fend_q ? '0 : new_max;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && red_valid_q) begin
      out_med_q  <= med_val;
      out_rend_q <= red_rend_q;
      out_fend_q <= red_fend_q;
      out_min_q  <= new_min;
      out_max_q  <= new_max;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_median_o    = out_med_q;
  assign out_row_end_o   = out_rend_q;
  assign out_frame_end_o = out_fend_q;
  assign out_frame_min_o = out_min_q;
  assign out_frame_max_o = out_max_q;

endmodule
